// ----- hw/rtl/sctc_pkg.sv -----
// Package for the set-1 scancode translator.
// Holds key codes, command and scroll codes, keymap sizing and shared types.
// No dependencies.
package sctc_pkg;

    // Default keymap geometry
    localparam int KEYMAP_ROWS_DEF    = 104;
    localparam int KEYMAP_COLUMNS_DEF = 10;

    localparam int COL_W = 4;

    // Item commands
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_MAP  = 1'b1;

    // Scancodes of interest
    localparam logic [7:0] KEY_EXT_PREFIX = 8'd224;
    localparam logic [7:0] KEY_CAPS       = 8'h3A;
    localparam logic [7:0] KEY_NUM        = 8'h45;
    localparam logic [7:0] KEY_SCROLL     = 8'h46;
    localparam logic [7:0] KEY_CTRL       = 8'd29;
    localparam logic [7:0] KEY_LSHIFT     = 8'd42;
    localparam logic [7:0] KEY_RSHIFT     = 8'd54;
    localparam logic [7:0] KEY_ALT        = 8'd56;
    localparam logic [7:0] KEY_BREAK      = 8'd128;
    localparam logic [7:0] KEY_PGUP       = 8'd73;
    localparam logic [7:0] KEY_PGDN       = 8'd81;
    localparam logic [7:0] KEY_LOOKUP_MAX = 8'd103;

    // LED command byte the host sends ahead of led_bits
    localparam logic [7:0] LED_CMD = 8'hED;

    // Modifier and LED bit positions
    localparam int MOD_CTRL   = 0;
    localparam int MOD_SHIFT  = 1;
    localparam int MOD_ALT    = 2;
    localparam int LED_SCROLL = 0;
    localparam int LED_NUM    = 1;
    localparam int LED_CAPS   = 2;

    // Scroll request codes
    localparam logic [1:0] SCROLL_NONE = 2'd0;
    localparam logic [1:0] SCROLL_UP   = 2'd1;
    localparam logic [1:0] SCROLL_DOWN = 2'd2;

    // Keymap column codes
    localparam logic [COL_W-1:0] COL_PLAIN      = 4'd0;
    localparam logic [COL_W-1:0] COL_SHIFT      = 4'd1;
    localparam logic [COL_W-1:0] COL_CTRL       = 4'd2;
    localparam logic [COL_W-1:0] COL_ALT        = 4'd3;
    localparam logic [COL_W-1:0] COL_ALT_SHIFT  = 4'd4;
    localparam logic [COL_W-1:0] COL_CTRL_SHIFT = 4'd5;
    localparam logic [COL_W-1:0] COL_CTRL_ALT   = 4'd6;
    localparam logic [COL_W-1:0] COL_ALL        = 4'd7;
    localparam logic [COL_W-1:0] COL_CAPS       = 4'd8;
    localparam logic [COL_W-1:0] COL_CAPS_SHIFT = 4'd9;

    // Per-item decode handed from the state tracker to the pipeline
    typedef struct packed {
        logic             lookup;
        logic [COL_W-1:0] column;
        logic             led_update;
        logic [2:0]       led_bits;
        logic [1:0]       scroll;
    } t_key_info;

endpackage

// ----- hw/rtl/sctc_keymap.sv -----
// Keymap storage: one write port, one registered read port.
// Depends on nothing; sized by the parent.
module sctc_keymap #(
    parameter int DEPTH = 1040,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/sctc_state.sv -----
// Modifier, lock LED and extended-prefix tracking for the scancode translator.
// Depends on sctc_pkg.
module sctc_state (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic [7:0]         i_key,
    output sctc_pkg::t_key_info o_info
);
    import sctc_pkg::*;

    logic [2:0] r_mod, n_mod;
    logic [2:0] r_led, n_led;
    logic       r_ext, n_ext;
    logic [6:0] r_make, n_make;
    logic       ext_mid;
    logic       led_upd;
    logic [1:0] scroll;
    logic       lookup;
    logic [COL_W-1:0] col;

    always_comb begin
        n_mod   = r_mod;
        n_led   = r_led;
        ext_mid = r_ext;
        led_upd = 1'b0;
        n_make  = (r_ext && !i_key[7]) ? i_key[6:0] : r_make;

        case (i_key)
            KEY_EXT_PREFIX: ext_mid = 1'b1;
            KEY_CAPS: begin
                n_led[LED_CAPS] = ~r_led[LED_CAPS];
                led_upd = 1'b1;
            end
            KEY_NUM: begin
                n_led[LED_NUM] = ~r_led[LED_NUM];
                led_upd = 1'b1;
            end
            KEY_SCROLL: begin
                n_led[LED_SCROLL] = ~r_led[LED_SCROLL];
                led_upd = 1'b1;
            end
            KEY_CTRL:              n_mod[MOD_CTRL]  = 1'b1;
            KEY_CTRL | KEY_BREAK:  n_mod[MOD_CTRL]  = 1'b0;
            KEY_LSHIFT, KEY_RSHIFT: n_mod[MOD_SHIFT] = 1'b1;
            KEY_LSHIFT | KEY_BREAK, KEY_RSHIFT | KEY_BREAK: n_mod[MOD_SHIFT] = 1'b0;
            KEY_ALT:               n_mod[MOD_ALT]   = 1'b1;
            KEY_ALT | KEY_BREAK:   n_mod[MOD_ALT]   = 1'b0;
            default: ;
        endcase

        lookup = 1'b0;
        scroll = SCROLL_NONE;
        n_ext  = ext_mid;
        if (!ext_mid) begin
            lookup = (i_key <= KEY_LOOKUP_MAX);
        end else begin
            // extended mode ends on the break of the key that followed E0
            if (i_key == {1'b1, n_make}) begin
                n_ext = 1'b0;
            end
            if (i_key == KEY_PGUP) begin
                scroll = SCROLL_UP;
            end else if (i_key == KEY_PGDN) begin
                scroll = SCROLL_DOWN;
            end
        end

        // column priority
        if (n_mod == 3'b111) begin
            col = COL_ALL;
        end else if (n_mod == 3'b101) begin
            col = COL_CTRL_ALT;
        end else if (n_mod == 3'b011) begin
            col = COL_CTRL_SHIFT;
        end else if (n_mod == 3'b110) begin
            col = COL_ALT_SHIFT;
        end else if (n_mod[MOD_SHIFT] && n_led[LED_CAPS]) begin
            col = COL_CAPS_SHIFT;
        end else if (n_mod == 3'b000 && n_led[LED_CAPS]) begin
            col = COL_CAPS;
        end else if (n_mod == 3'b000) begin
            col = COL_PLAIN;
        end else if (n_mod[MOD_CTRL]) begin
            col = COL_CTRL;
        end else if (n_mod[MOD_ALT]) begin
            col = COL_ALT;
        end else begin
            col = COL_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod  <= '0;
            r_led  <= '0;
            r_ext  <= 1'b0;
            r_make <= '0;
        end else if (i_load) begin
            r_mod  <= n_mod;
            r_led  <= n_led;
            r_ext  <= n_ext;
            r_make <= n_make;
        end
    end

    assign o_info.lookup     = lookup;
    assign o_info.column     = col;
    assign o_info.led_update = led_upd;
    assign o_info.led_bits   = n_led;
    assign o_info.scroll     = scroll;
endmodule

// ----- hw/rtl/scancode_to_char_translator.sv -----
// Top level of the set-1 scancode to character translator.
// Depends on sctc_pkg, sctc_state and sctc_keymap.
//
// Takes one beat per cycle unless stalled: a scancode (cmd 0) or a keymap write (cmd 1).
// Modifier, lock LED and E0-prefix state update in the accept cycle, which also
// launches the keymap read; the next cycle forms the result from the registered
// read data, which is loaded into the output register once that register is
// empty or being drained; a new beat may follow every cycle unless input stalls.
// Input stalls only when that result stage is full and the output register is
// held by a stall. Keymap writes and quiet scancodes (no character, no LED
// change, no scroll) produce no output beat.
// On an output beat with led_update set, the host sends 0xED and then led_bits.
// The keymap holds no reset value: a lookup of an entry never written returns
// an arbitrary byte. Writes outside the row/column range are dropped. There is
// no clearing pass; the block takes beats straight out of reset.
module scancode_to_char_translator #(
    parameter int KEYMAP_ROWS    = sctc_pkg::KEYMAP_ROWS_DEF,
    parameter int KEYMAP_COLUMNS = sctc_pkg::KEYMAP_COLUMNS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_scancode,
    input  logic [6:0] i_map_row,
    input  logic [3:0] i_map_column,
    input  logic [7:0] i_map_value,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_char_valid,
    output logic [7:0] o_char_code,
    output logic       o_led_update,
    output logic [2:0] o_led_bits,
    output logic [1:0] o_scroll_request
);
    import sctc_pkg::*;

    localparam int DEPTH = KEYMAP_ROWS * KEYMAP_COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    logic      in_acc, scan_acc, map_acc;
    t_key_info info;
    logic [AW-1:0] waddr, raddr;
    logic [7:0] rdata;

    // result-forming stage
    logic      r_p_valid, n_p_valid;
    t_key_info r_p_info;
    logic      p_move;
    logic [7:0] p_char;
    logic      p_has;

    // output register
    logic       r_o_valid, n_o_valid;
    logic       r_o_char_valid;
    logic [7:0] r_o_char_code;
    logic       r_o_led_update;
    logic [2:0] r_o_led_bits;
    logic [1:0] r_o_scroll;

    // stage P moves on when the output register is empty or being drained
    assign p_move   = r_p_valid && (!r_o_valid || !i_stall);
    assign o_stall  = r_p_valid && !p_move;
    assign in_acc   = i_valid && !o_stall;
    assign scan_acc = in_acc && (i_cmd == CMD_SCAN);
    assign map_acc  = in_acc && (i_cmd == CMD_MAP)
                      && (32'(i_map_row) < KEYMAP_ROWS)
                      && (32'(i_map_column) < KEYMAP_COLUMNS);

    sctc_state u_state (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (scan_acc),
        .i_key  (i_scancode),
        .o_info (info)
    );

    // row * columns + column; the lookup path only sees codes up to 103
    assign waddr = AW'(32'(i_map_row) * KEYMAP_COLUMNS + 32'(i_map_column));
    assign raddr = AW'(32'(i_scancode[6:0]) * KEYMAP_COLUMNS + 32'(info.column));

    sctc_keymap #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_keymap (
        .i_clk  (i_clk),
        .i_we   (map_acc),
        .i_waddr(waddr),
        .i_wdata(i_map_value),
        .i_re   (scan_acc && info.lookup),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign n_p_valid = scan_acc || (r_p_valid && !p_move);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_acc) begin
            r_p_info <= info;
        end
    end

    assign p_char = r_p_info.lookup ? rdata : 8'd0;
    assign p_has  = (p_char != 8'd0) || r_p_info.led_update
                    || (r_p_info.scroll != SCROLL_NONE);

    // quiet items leave stage P without touching the output register
    assign n_o_valid = p_move ? p_has : (r_o_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_move && p_has) begin
            r_o_char_valid <= (p_char != 8'd0);
            r_o_char_code  <= p_char;
            r_o_led_update <= r_p_info.led_update;
            r_o_led_bits   <= r_p_info.led_bits;
            r_o_scroll     <= r_p_info.scroll;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_char_valid     = r_o_char_valid;
    assign o_char_code      = r_o_char_code;
    assign o_led_update     = r_o_led_update;
    assign o_led_bits       = r_o_led_bits;
    assign o_scroll_request = r_o_scroll;
endmodule

// ----- hw/rtl/sctc_checker.sv -----
// Port-level checks for the scancode translator, bound to the top level.
// Depends on sctc_pkg.
module sctc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_char_valid,
    input logic [7:0] o_char_code,
    input logic       o_led_update,
    input logic [2:0] o_led_bits,
    input logic [1:0] o_scroll_request
);
    import sctc_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_char_code)
            && $stable(o_led_bits) && $stable(o_scroll_request))
        else $error("stalled result beat changed");

    // no quiet beats
    a_not_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_char_valid || o_led_update || (o_scroll_request != SCROLL_NONE))
        else $error("result beat carries nothing");

    a_char_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_valid == (o_char_code != 8'd0)))
        else $error("char_valid disagrees with char_code");

    // lock keys never scroll
    a_led_no_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_led_update |-> (o_scroll_request == SCROLL_NONE))
        else $error("LED update with scroll request");
endmodule

bind scancode_to_char_translator sctc_checker u_sctc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_char_valid    (o_char_valid),
    .o_char_code     (o_char_code),
    .o_led_update    (o_led_update),
    .o_led_bits      (o_led_bits),
    .o_scroll_request(o_scroll_request)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for scancode_to_char_translator.
// Depends on sctc_pkg and the RTL top; holds its own model of keymap and key state.
module tb_top;
    import sctc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
    localparam int RANDOM_BEATS   = 730;   // on top of the keymap load and directed beats

    // One output beat as the translator should present it
    typedef struct {
        logic       char_valid;
        logic [7:0] char_code;
        logic       led_update;
        logic [2:0] led_bits;
        logic [1:0] scroll;
    } t_char_beat;

    // Shadow of the translator: keymap, modifiers, lock LEDs and E0 state.
    // note_beat() advances the shadow for every accepted input beat and queues
    // the output beat it implies; check_char_beat() pops and compares.
    class translation_checker;
        logic [7:0] map_copy [KEYMAP_ROWS_DEF][KEYMAP_COLUMNS_DEF];
        logic [2:0] mods     = '0;
        logic [2:0] leds     = '0;
        logic       ext_on   = 1'b0;
        logic [6:0] ext_code = '0;
        t_char_beat expected_chars [$];
        int         mismatches = 0;

        // Modifier/caps priority, first match wins
        function logic [COL_W-1:0] pick_col();
            logic ctrl, shift, alt, caps;
            ctrl  = mods[MOD_CTRL];
            shift = mods[MOD_SHIFT];
            alt   = mods[MOD_ALT];
            caps  = leds[LED_CAPS];
            if (ctrl && shift && alt) return COL_ALL;
            if (ctrl && alt && !shift) return COL_CTRL_ALT;
            if (ctrl && shift && !alt) return COL_CTRL_SHIFT;
            if (alt && shift && !ctrl) return COL_ALT_SHIFT;
            if (shift && caps) return COL_CAPS_SHIFT;
            if (mods == 3'b000 && caps) return COL_CAPS;
            if (mods == 3'b000) return COL_PLAIN;
            if (ctrl) return COL_CTRL;
            if (alt) return COL_ALT;
            return COL_SHIFT;
        endfunction

        function void note_beat(logic cmd, logic [7:0] sc, logic [6:0] row,
                                logic [3:0] col, logic [7:0] val);
            logic [7:0] ch;
            logic       upd;
            logic [1:0] scr;
            t_char_beat r;
            ch  = '0;
            upd = 1'b0;
            scr = SCROLL_NONE;
            if (cmd == CMD_MAP) begin
                // out-of-range writes are dropped
                if (row < KEYMAP_ROWS_DEF && col < KEYMAP_COLUMNS_DEF)
                    map_copy[row][col] = val;
                return;
            end
            if (ext_on && !sc[7])
                ext_code = sc[6:0];
            case (sc)
                KEY_EXT_PREFIX:                 ext_on = 1'b1;
                KEY_CAPS: begin
                    leds[LED_CAPS] = ~leds[LED_CAPS];
                    upd = 1'b1;
                end
                KEY_NUM: begin
                    leds[LED_NUM] = ~leds[LED_NUM];
                    upd = 1'b1;
                end
                KEY_SCROLL: begin
                    leds[LED_SCROLL] = ~leds[LED_SCROLL];
                    upd = 1'b1;
                end
                KEY_CTRL:                       mods[MOD_CTRL]  = 1'b1;
                KEY_CTRL + KEY_BREAK:           mods[MOD_CTRL]  = 1'b0;
                KEY_LSHIFT, KEY_RSHIFT:         mods[MOD_SHIFT] = 1'b1;
                KEY_LSHIFT + KEY_BREAK,
                KEY_RSHIFT + KEY_BREAK:         mods[MOD_SHIFT] = 1'b0;
                KEY_ALT:                        mods[MOD_ALT]   = 1'b1;
                KEY_ALT + KEY_BREAK:            mods[MOD_ALT]   = 1'b0;
                default: ;
            endcase
            if (!ext_on) begin
                if (sc <= KEY_LOOKUP_MAX)
                    ch = map_copy[sc][pick_col()];
            end else begin
                // break of the code seen after E0 closes extended mode; a
                // prefix with a held code of 96 closes it on the spot
                if (sc == {1'b1, ext_code})
                    ext_on = 1'b0;
                if (sc == KEY_PGUP)
                    scr = SCROLL_UP;
                else if (sc == KEY_PGDN)
                    scr = SCROLL_DOWN;
            end
            if (ch == 8'd0 && !upd && scr == SCROLL_NONE)
                return;
            r.char_valid = (ch != 8'd0);
            r.char_code  = ch;
            r.led_update = upd;
            r.led_bits   = leds;
            r.scroll     = scr;
            expected_chars.push_back(r);
        endfunction

        function void check_char_beat(logic cv, logic [7:0] cc, logic lu,
                                      logic [2:0] lb, logic [1:0] sr);
            t_char_beat e;
            if (expected_chars.size() == 0) begin
                $error("unexpected output beat: char_valid %0b char_code %0h", cv, cc);
                mismatches++;
                return;
            end
            e = expected_chars.pop_front();
            if (cv !== e.char_valid) begin
                $error("char_valid: expected %0b, got %0b", e.char_valid, cv);
                mismatches++;
            end
            if (cc !== e.char_code) begin
                $error("char_code: expected %0h, got %0h", e.char_code, cc);
                mismatches++;
            end
            if (lu !== e.led_update) begin
                $error("led_update: expected %0b, got %0b", e.led_update, lu);
                mismatches++;
            end
            if (lb !== e.led_bits) begin
                $error("led_bits: expected %0h, got %0h", e.led_bits, lb);
                mismatches++;
            end
            if (sr !== e.scroll) begin
                $error("scroll_request: expected %0d, got %0d", e.scroll, sr);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    // Clock, reset and DUT-facing signals; all inputs known from time zero
    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       beat_valid     = 1'b0;
    logic       dut_stall;
    logic       beat_cmd       = CMD_SCAN;
    logic [7:0] beat_scancode  = '0;
    logic [6:0] beat_row       = '0;
    logic [3:0] beat_column    = '0;
    logic [7:0] beat_value     = '0;
    logic       res_valid;
    logic       res_stall      = 1'b0;
    logic       res_char_valid;
    logic [7:0] res_char_code;
    logic       res_led_update;
    logic [2:0] res_led_bits;
    logic [1:0] res_scroll;

    translation_checker chk;
    int idle_cycles = 0;
    int live_beats  = 0;   // accepted beats, minus dropped keymap writes
    int burst_left  = 0;   // while nonzero the sender runs back to back

    scancode_to_char_translator i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (beat_valid),
        .o_stall          (dut_stall),
        .i_cmd            (beat_cmd),
        .i_scancode       (beat_scancode),
        .i_map_row        (beat_row),
        .i_map_column     (beat_column),
        .i_map_value      (beat_value),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_char_valid     (res_char_valid),
        .o_char_code      (res_char_code),
        .o_led_update     (res_led_update),
        .o_led_bits       (res_led_bits),
        .o_scroll_request (res_scroll)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Keymap bytes: about a quarter zero so that quiet lookups happen
    function automatic logic [7:0] pick_map_value();
        if ($urandom_range(0, 3) == 0) return 8'd0;
        return 8'($urandom_range(1, 255));
    endfunction

    // Drive one input beat and hold it until accepted. Valid stays high into
    // the next beat when no gap is drawn, so it is never dropped and raised
    // in one step. Inputs and stall are sampled right after the edge, before
    // any flop update of that edge lands.
    task automatic send_beat(input logic cmd, input logic [7:0] sc,
                             input logic [6:0] row, input logic [3:0] col,
                             input logic [7:0] val);
        int gap;
        gap = (burst_left > 0) ? 0 : pick_gap();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0) begin
            beat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        beat_valid    <= 1'b1;
        beat_cmd      <= cmd;
        beat_scancode <= sc;
        beat_row      <= row;
        beat_column   <= col;
        beat_value    <= val;
        @(posedge clk);
        while (dut_stall !== 1'b0) @(posedge clk);
        chk.note_beat(cmd, sc, row, col, val);
        if (!(cmd == CMD_MAP && (row >= KEYMAP_ROWS_DEF || col >= KEYMAP_COLUMNS_DEF)))
            live_beats++;
    endtask

    // Unused fields carry noise so the block must ignore them
    task automatic send_key(input logic [7:0] sc);
        send_beat(CMD_SCAN, sc, 7'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic send_map(input logic [6:0] row, input logic [3:0] col,
                            input logic [7:0] val);
        send_beat(CMD_MAP, 8'($urandom), row, col, val);
    endtask

    function automatic logic [7:0] pick_modifier();
        case ($urandom_range(0, 3))
            0:       return KEY_CTRL;
            1:       return KEY_LSHIFT;
            2:       return KEY_RSHIFT;
            default: return KEY_ALT;
        endcase
    endfunction

    function automatic logic [7:0] pick_lock();
        case ($urandom_range(0, 2))
            0:       return KEY_CAPS;
            1:       return KEY_NUM;
            default: return KEY_SCROLL;
        endcase
    endfunction

    // The keymap has no reset value, so every entry is loaded before the
    // first lookup can reach it.
    task automatic load_keymap();
        for (int row = 0; row < KEYMAP_ROWS_DEF; row++)
            for (int col = 0; col < KEYMAP_COLUMNS_DEF; col++)
                send_map(7'(row), 4'(col), pick_map_value());
    endtask

    // Field extremes, each modifier column path, locks, scroll keys and the
    // odd corners of the E0 handling
    task automatic directed_beats();
        send_map(7'd127, 4'd15, 8'hAA);            // dropped: row and column out of range
        send_map(7'd0, 4'd0, 8'hFF);
        send_map(7'(KEY_LOOKUP_MAX), 4'd9, 8'h81);
        send_key(8'd0);
        send_key(KEY_LOOKUP_MAX);
        send_key(KEY_LOOKUP_MAX + 8'd1);           // first code past the keymap
        send_key(8'd255);
        send_key(KEY_CAPS);
        send_key(KEY_LOOKUP_MAX);                  // caps column
        send_key(KEY_LSHIFT);
        send_key(KEY_LOOKUP_MAX);                  // caps + shift column
        send_key(KEY_CAPS);
        send_key(KEY_CTRL);
        send_key(KEY_ALT);
        send_key(8'h10);                           // all three modifiers
        send_key(KEY_LSHIFT + KEY_BREAK);
        send_key(KEY_CTRL + KEY_BREAK);
        send_key(KEY_ALT + KEY_BREAK);
        send_key(KEY_NUM);
        send_key(KEY_SCROLL);
        send_key(KEY_EXT_PREFIX);
        send_key(KEY_PGUP);
        send_key(KEY_PGUP + KEY_BREAK);            // closes extended mode
        send_key(KEY_EXT_PREFIX);
        send_key(8'd96);
        send_key(KEY_EXT_PREFIX);                  // held code 96: closes at once
        send_key(KEY_EXT_PREFIX);
        send_key(KEY_EXT_PREFIX);                  // held code still 96: the repeated prefix closes it again
        send_key(KEY_PGDN);
        send_key(KEY_PGDN + KEY_BREAK);
    endtask

    // Mostly well-formed key traffic with random content, plus keymap
    // rewrites, noise bytes and dangling prefixes
    task automatic random_traffic();
        int stop_at, next_pause, r;
        logic [7:0] code;
        stop_at    = live_beats + RANDOM_BEATS;
        next_pause = live_beats + $urandom_range(150, 400);
        while (live_beats < stop_at) begin
            if (live_beats >= next_pause) begin
                // drain: hold off until every queued result has come back
                beat_valid <= 1'b0;
                @(posedge clk);
                while (chk.pending() != 0) @(posedge clk);
                next_pause = live_beats + $urandom_range(150, 400);
            end
            if (burst_left == 0 && $urandom_range(0, 59) == 0)
                burst_left = $urandom_range(20, 60);
            r = $urandom_range(0, 99);
            if (r < 40) begin
                code = 8'($urandom_range(0, KEY_LOOKUP_MAX));
                send_key(code);
                if ($urandom_range(0, 3) != 0)
                    send_key(code | KEY_BREAK);
            end else if (r < 55) begin
                code = pick_modifier();
                send_key($urandom_range(0, 1) ? code : code + KEY_BREAK);
            end else if (r < 63) begin
                code = pick_lock();
                send_key(code);
                if ($urandom_range(0, 1))
                    send_key(code + KEY_BREAK);
            end else if (r < 75) begin
                if ($urandom_range(0, 1))
                    code = $urandom_range(0, 1) ? KEY_PGUP : KEY_PGDN;
                else
                    code = 8'($urandom_range(0, 127));
                send_key(KEY_EXT_PREFIX);
                send_key(code);
                if ($urandom_range(0, 4) != 0) begin
                    send_key(KEY_EXT_PREFIX);
                    send_key(code | KEY_BREAK);
                end
            end else if (r < 83) begin
                send_map($urandom_range(0, 9) == 0 ? 7'($urandom_range(0, 127))
                                                   : 7'($urandom_range(0, KEY_LOOKUP_MAX)),
                         $urandom_range(0, 9) == 0 ? 4'($urandom_range(0, 15))
                                                   : 4'($urandom_range(0, 9)),
                         pick_map_value());
            end else if (r < 91) begin
                send_key(8'($urandom_range(0, 255)));
            end else begin
                send_key(KEY_EXT_PREFIX);
                if ($urandom_range(0, 1))
                    send_key(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Output-side backpressure: calm stretches, long holds, choppy bursts
    initial begin
        forever begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    res_stall <= 1'b0;
                    repeat ($urandom_range(20, 150)) @(posedge clk);
                end
                2: begin
                    res_stall <= 1'b1;
                    repeat ($urandom_range(20, 60)) @(posedge clk);
                end
                default: begin
                    repeat ($urandom_range(5, 40)) begin
                        res_stall <= ($urandom_range(0, 99) < 35);
                        @(posedge clk);
                    end
                end
            endcase
        end
    end

    // Every output beat taken is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall)
            chk.check_char_beat(res_char_valid, res_char_code, res_led_update,
                                 res_led_bits, res_scroll);
    end

    // Hang guard: no beat on either channel for too long ends the run
    always @(posedge clk) begin
        if ((beat_valid && dut_stall === 1'b0) || (res_valid === 1'b1 && !res_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        chk = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        load_keymap();
        directed_beats();
        random_traffic();
        beat_valid <= 1'b0;
        @(posedge clk);
        while (chk.pending() != 0) @(posedge clk);
        // the spare cycles below catch stray output beats
        repeat (10) @(posedge clk);
        if (chk.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
